[design/mau_pkg.sv]
// Package for the modular arithmetic unit: operation kinds, shared-unit ops,
// status struct and width constants. No dependencies.
package mau_pkg;

  localparam int MOD_WIDTH_DEF = 32;
  localparam int OPERAND_W     = 64;
  localparam int RESULT_W      = 32;
  localparam int KIND_W        = 3;
  localparam int CFG_DATA_W    = 32;
  localparam int CFG_ADDR_W    = 3;

  localparam logic [CFG_ADDR_W-1:0] REG_MODULUS = 3'd0;

  localparam logic [KIND_W-1:0] K_ADD = 3'd0;
  localparam logic [KIND_W-1:0] K_SUB = 3'd1;
  localparam logic [KIND_W-1:0] K_MUL = 3'd2;
  localparam logic [KIND_W-1:0] K_POW = 3'd3;
  localparam logic [KIND_W-1:0] K_DIV = 3'd4;

  // shared unit operations
  typedef enum logic [1:0] {
    U_SHIFT,    // r = (2r + bit) mod d, quotient bit out
    U_MULSTEP,  // r = (2r + bit*x) mod d
    U_ADD,      // r = (r + x) mod d
    U_SUB       // r = (r - x) mod d
  } mau_uop_t;

  typedef struct packed {
    logic valid;
    logic not_inv;
  } mau_done_t;

endpackage

[design/mau_step_unit.sv]
// Shared compare/subtract step unit of the modular arithmetic unit.
// Depends on mau_pkg.
module mau_step_unit #(
  parameter int MW = 32
) (
  input  mau_pkg::mau_uop_t op,
  input  logic [MW-1:0]     r,
  input  logic [MW-1:0]     x,
  input  logic              bit_in,
  input  logic [MW-1:0]     d,
  output logic [MW-1:0]     res,
  output logic              qbit
);
  import mau_pkg::*;

  logic [MW:0] dd, sh, dbl, d1, sum, sum2, diff, t;
  logic        ge;

  always_comb begin
    dd   = {1'b0, d};
    sh   = {r, bit_in};
    ge   = (sh >= dd);
    dbl  = {r, 1'b0};
    d1   = (dbl >= dd) ? dbl - dd : dbl;
    sum  = d1 + (bit_in ? {1'b0, x} : '0);
    sum2 = {1'b0, r} + {1'b0, x};
    diff = {1'b0, r} - {1'b0, x};
    qbit = 1'b0;
    unique case (op)
      U_SHIFT: begin
        t    = ge ? sh - dd : sh;
        qbit = ge;
      end
      U_MULSTEP: t = (sum >= dd) ? sum - dd : sum;
      U_ADD:     t = (sum2 >= dd) ? sum2 - dd : sum2;
      U_SUB:     t = (r >= x) ? diff : diff + dd;
      default:   t = '0;
    endcase
    res = t[MW-1:0];
  end

endmodule

[design/mau_ctrl.sv]
// Sequencer of the modular arithmetic unit: operand reduction, bit-serial
// modular multiply, square-and-multiply and extended Euclid on mau_step_unit.
// Depends on mau_pkg and mau_step_unit.
module mau_ctrl #(
  parameter int MW = mau_pkg::MOD_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic [mau_pkg::KIND_W-1:0]     kind_in,
  input  logic [mau_pkg::OPERAND_W-1:0]  a_in,
  input  logic [mau_pkg::OPERAND_W-1:0]  b_in,
  input  logic [mau_pkg::CFG_DATA_W-1:0] modulus,
  input  logic                           out_free,
  output logic                           in_ready,
  output mau_pkg::mau_done_t             done,
  output logic [MW-1:0]                  result
);
  import mau_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_RED, S_NEG, S_DISP, S_MUL, S_POW,
    S_DIVCHK, S_DIVSTEP, S_DIVUPD, S_DONE
  } state_t;

  typedef enum logic [1:0] {R_OUT, R_PRES, R_BASE, R_SPROD} ret_t;

  localparam logic [5:0] LAST_RED = 6'(OPERAND_W - 1);
  localparam logic [5:0] LAST_MW  = 6'(MW - 1);

  state_t              state;
  ret_t                ret;
  logic [KIND_W-1:0]   kind;
  logic [OPERAND_W-1:0] src, e;
  logic [5:0]          cnt;
  logic                neg, sel_b, flag;
  logic [MW-1:0]       m, acc, mx, my, a_r, b_r, pres, base;
  logic [MW-1:0]       r0, r1, s0, s1, q, rem, out_res;
  logic [MW-1:0]       m_eff, one_m;

  mau_uop_t      u_op;
  logic [MW-1:0] u_r, u_x, u_d, u_res;
  logic          u_bit, u_q, red_fin;

  mau_step_unit #(.MW(MW)) u_step (
    .op(u_op), .r(u_r), .x(u_x), .bit_in(u_bit), .d(u_d), .res(u_res), .qbit(u_q)
  );

  assign m_eff = (modulus[MW-1:0] == '0) ? MW'(1) : modulus[MW-1:0];
  assign one_m = (m == MW'(1)) ? '0 : MW'(1);

  always_comb begin
    u_op  = U_ADD;
    u_r   = acc;
    u_x   = mx;
    u_bit = 1'b0;
    u_d   = m;
    unique case (state)
      S_RED: begin
        u_op  = U_SHIFT;
        u_bit = src[OPERAND_W-1];
      end
      S_NEG: begin
        u_op = U_SUB;
        u_r  = '0;
        u_x  = acc;
      end
      S_DISP: begin
        u_op = (kind == K_SUB) ? U_SUB : U_ADD;
        u_r  = a_r;
        u_x  = b_r;
      end
      S_MUL: begin
        u_op  = U_MULSTEP;
        u_bit = my[MW-1];
      end
      S_DIVSTEP: begin
        u_op  = U_SHIFT;
        u_bit = my[MW-1];
        u_d   = r1;
      end
      S_DIVUPD: begin
        u_op = U_SUB;
        u_r  = s0;
        u_x  = acc;
      end
      default: ;
    endcase
    red_fin = (state == S_RED && cnt == LAST_RED && !neg) || state == S_NEG;
  end

  assign in_ready     = (state == S_IDLE);
  assign done.valid   = (state == S_DONE);
  assign done.not_inv = flag;
  assign result       = out_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      flag  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) begin
          kind  <= kind_in;
          e     <= b_in;
          m     <= m_eff;
          acc   <= '0;
          cnt   <= '0;
          sel_b <= 1'b0;
          flag  <= 1'b0;
          neg   <= a_in[OPERAND_W-1];
          src   <= a_in[OPERAND_W-1] ? ~a_in + OPERAND_W'(1) : a_in;
          state <= S_RED;
        end
        S_RED, S_NEG: begin
          acc <= u_res;
          if (state == S_RED) begin
            src <= {src[OPERAND_W-2:0], 1'b0};
            cnt <= cnt + 6'd1;
            if (cnt == LAST_RED && neg) state <= S_NEG;
          end
          if (red_fin) begin
            cnt <= '0;
            if (!sel_b) begin
              a_r   <= u_res;
              sel_b <= 1'b1;
              acc   <= '0;
              neg   <= e[OPERAND_W-1];
              src   <= e[OPERAND_W-1] ? ~e + OPERAND_W'(1) : e;
              state <= S_RED;
            end else begin
              b_r   <= u_res;
              state <= S_DISP;
            end
          end
        end
        S_DISP: begin
          acc <= '0;
          cnt <= '0;
          priority case (kind)
            K_ADD, K_SUB: begin
              out_res <= u_res;
              state   <= S_DONE;
            end
            K_MUL: begin
              mx    <= a_r;
              my    <= b_r;
              ret   <= R_OUT;
              state <= S_MUL;
            end
            K_POW: begin
              pres <= one_m;
              base <= a_r;
              if (e[OPERAND_W-1]) begin
                out_res <= one_m;
                state   <= S_DONE;
              end else begin
                state <= S_POW;
              end
            end
            K_DIV: begin
              r0    <= m;
              r1    <= b_r;
              s0    <= '0;
              s1    <= one_m;
              state <= S_DIVCHK;
            end
            default: begin
              out_res <= '0;
              state   <= S_DONE;
            end
          endcase
        end
        S_POW: begin
          acc <= '0;
          cnt <= '0;
          priority if (e == '0) begin
            out_res <= pres;
            state   <= S_DONE;
          end else if (e[0]) begin
            mx    <= base;
            my    <= pres;
            ret   <= R_PRES;
            e[0]  <= 1'b0;
            state <= S_MUL;
          end else begin
            mx    <= base;
            my    <= base;
            ret   <= R_BASE;
            e     <= e >> 1;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          acc <= u_res;
          my  <= my << 1;
          cnt <= cnt + 6'd1;
          if (cnt == LAST_MW) begin
            cnt <= '0;
            unique case (ret)
              R_OUT: begin
                out_res <= u_res;
                state   <= S_DONE;
              end
              R_PRES: begin
                pres  <= u_res;
                state <= S_POW;
              end
              R_BASE: begin
                base  <= u_res;
                state <= S_POW;
              end
              R_SPROD: state <= S_DIVUPD;
              default: state <= S_DONE;
            endcase
          end
        end
        S_DIVCHK: begin
          acc <= '0;
          cnt <= '0;
          priority if (r1 == '0) begin
            if (r0 == MW'(1)) begin
              mx    <= a_r;
              my    <= s0;
              ret   <= R_OUT;
              state <= S_MUL;
            end else begin
              out_res <= '0;
              flag    <= 1'b1;
              state   <= S_DONE;
            end
          end else begin
            my    <= r0;
            q     <= '0;
            state <= S_DIVSTEP;
          end
        end
        S_DIVSTEP: begin
          acc <= u_res;
          my  <= my << 1;
          q   <= {q[MW-2:0], u_q};
          cnt <= cnt + 6'd1;
          if (cnt == LAST_MW) begin
            cnt   <= '0;
            rem   <= u_res;
            acc   <= '0;
            mx    <= s1;
            my    <= {q[MW-2:0], u_q};
            ret   <= R_SPROD;
            state <= S_MUL;
          end
        end
        S_DIVUPD: begin
          s1    <= u_res;
          s0    <= s1;
          r0    <= r1;
          r1    <= rem;
          state <= S_DIVCHK;
        end
        S_DONE: if (out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  a_res_range: assert property (@(posedge clk) disable iff (rst)
    done.valid |-> out_res < m) else $error("result not reduced");

  a_flag_div: assert property (@(posedge clk) disable iff (rst)
    done.valid && done.not_inv |-> kind == K_DIV) else $error("flag on non-divide");

  a_mul_acc: assert property (@(posedge clk) disable iff (rst)
    state == S_MUL |-> acc < m) else $error("multiply accumulator out of range");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("accepted word while busy");

endmodule

[design/modular_arithmetic_unit_top.sv]
// Modular arithmetic unit, top level: APB modulus register, input stream,
// sequencer with shared step unit, and the output word register.
// Depends on mau_pkg, mau_ctrl and mau_step_unit.
//
// Takes one word (kind in s_tuser, two signed 64-bit operands in s_tdata),
// reduces both operands mod m, and returns one word with the add, subtract,
// multiply, power or divide result mod m and a not-invertible flag. Words are
// handled one at a time by a sequencer driving one compare/subtract unit.
// Each operand is reduced bit-serially, with a negate step when negative;
// then the sequencer runs add/sub, a bit-serial modular multiply, power (one
// bit-serial modular multiply per square and per set exponent bit) or divide
// (Euclid steps, each a bit-serial division, a multiply and a subtract, up to
// ~46 steps for a 32-bit modulus, plus a final multiply). s_tready is high
// only between words; a finished word sits in the output register until
// taken, and the next word is accepted meanwhile. A modulus of 0 acts as 1;
// register bits above MOD_WIDTH are ignored. Write the modulus only while
// the block is idle.
module modular_arithmetic_unit_top #(
  parameter int MOD_WIDTH = mau_pkg::MOD_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // input stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [127:0]                    s_tdata,  // [63:0] operand_a, [127:64] operand_b
  input  logic [mau_pkg::KIND_W-1:0]      s_tuser,  // [2:0] kind
  // output stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [mau_pkg::RESULT_W-1:0]    m_tdata,  // [31:0] result
  output logic                            m_tuser,  // [0] not_invertible
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mau_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [mau_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [mau_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import mau_pkg::*;

  logic [CFG_DATA_W-1:0] modulus;
  logic                  out_free;
  mau_done_t             done;
  logic [MOD_WIDTH-1:0]  result;

  // modulus register, written on the APB access phase
  assign pready = 1'b1;
  assign prdata = (paddr == REG_MODULUS) ? modulus : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= CFG_DATA_W'(1);
    end else if (psel && penable && pwrite && pready && paddr == REG_MODULUS) begin
      modulus <= pwdata;
    end
  end

  // output register frees up the sequencer while a word waits downstream
  assign out_free = !m_tvalid || m_tready;

  mau_ctrl #(.MW(MOD_WIDTH)) u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(s_tvalid),
    .kind_in(s_tuser),
    .a_in(s_tdata[63:0]),
    .b_in(s_tdata[127:64]),
    .modulus(modulus),
    .out_free(out_free),
    .in_ready(s_tready),
    .done(done),
    .result(result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= done.valid;
      if (done.valid) begin
        m_tdata <= RESULT_W'(result);
        m_tuser <= done.not_inv;
      end
    end
  end

endmodule
